// File: rtl/radix_k_digit_sum_top_assert.svh
// ----------------------------------------------------------------------------
// radix_k_digit_sum_top_assert.svh
// assertion macros for the base-k digit sum block
// ----------------------------------------------------------------------------
`ifndef RADIX_K_DIGIT_SUM_TOP_ASSERT_SVH
`define RADIX_K_DIGIT_SUM_TOP_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define RKDS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked while out of reset
`define RKDS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/rkds_pkg.sv
// ----------------------------------------------------------------------------
// rkds_pkg
// shared constants and types of the base-k digit sum block
// ----------------------------------------------------------------------------
`default_nettype none

package rkds_pkg;

   // default width of value, radix and result
   localparam int VALUE_WIDTH_DEF = 32;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_WAIT,
      ST_DONE
   } seq_state_type;

endpackage : rkds_pkg

`default_nettype wire

// File: rtl/rkds_div.sv
// ----------------------------------------------------------------------------
// rkds_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rkds_div
   import rkds_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   div_start,
   input  wire logic [VALUE_WIDTH-1:0] dividend,
   input  wire logic [VALUE_WIDTH-1:0] divisor,
   output logic                        div_done,
   output logic [VALUE_WIDTH-1:0]      quotient,
   output logic [VALUE_WIDTH-1:0]      remainder
);

   localparam int CntW = $clog2(VALUE_WIDTH);

   logic                   run_ff, run_in;
   logic                   done_ff, done_in;
   logic [CntW-1:0]        cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] quot_ff, quot_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] dvs_ff, dvs_in;
   logic [VALUE_WIDTH:0]   shifted;
   logic [VALUE_WIDTH:0]   diff;
   logic                   ge;

   // one restoring step: shift in next dividend bit, trial subtract
   always_comb begin
      shifted = {rem_ff, quot_ff[VALUE_WIDTH-1]};
      ge      = shifted >= {1'b0, dvs_ff};
      diff    = shifted - {1'b0, dvs_ff};
   end

   // step control and datapath
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_start) begin
         run_in  = 1'b1;
         cnt_in  = CntW'(VALUE_WIDTH - 1);
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (run_ff) begin
         quot_in = {quot_ff[VALUE_WIDTH-2:0], ge};
         rem_in  = ge ? diff[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign div_done  = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule : rkds_div

`default_nettype wire

// File: rtl/radix_k_digit_sum_top.sv
// ----------------------------------------------------------------------------
// radix_k_digit_sum_top
// base-k digit sum of an unsigned value using one shared serial divider
// ----------------------------------------------------------------------------
// usage:
//   request channel: a transaction is taken when start is high and busy is
//   low; req_value_in is n and req_radix is k.
//   response channel: rsp_valid is high for exactly one cycle with the
//   digit sum on rsp_digit_sum; the receiver cannot stall it.
//   a radix of 0 or 1, or a radix above the value, returns the value itself
//   with rsp_valid high in the cycle right after the accepting edge.
//   otherwise each base-k digit costs one pass through the shared divider:
//   a launch, VALUE_WIDTH restoring steps and an update. busy stays high
//   until the response cycle has ended and falls when the sequencer
//   returns to idle, so one transaction is in flight at a time.
//   reset returns the sequencer to idle and drops any transaction in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "radix_k_digit_sum_top_assert.svh"

module radix_k_digit_sum_top
   import rkds_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [VALUE_WIDTH-1:0] req_value_in,
   input  wire logic [VALUE_WIDTH-1:0] req_radix,
   output logic                        rsp_valid,
   output logic [VALUE_WIDTH-1:0]      rsp_digit_sum
);

   seq_state_type          state_ff, state_in;
   logic [VALUE_WIDTH-1:0] n_ff, n_in;
   logic [VALUE_WIDTH-1:0] k_ff, k_in;
   logic [VALUE_WIDTH-1:0] sum_ff, sum_in;
   logic                   div_start;
   logic                   div_done;
   logic [VALUE_WIDTH-1:0] div_quot;
   logic [VALUE_WIDTH-1:0] div_rem;
   logic                   trivial;

   // shared divider
   rkds_div #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .dividend  (n_ff),
      .divisor   (k_ff),
      .div_done  (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // radix of 0 or 1, or above the value, gives the value itself
   assign trivial = (req_radix <= VALUE_WIDTH'(1)) || (req_radix > req_value_in);

   // sequencer: next state and datapath updates
   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      k_in      = k_ff;
      sum_in    = sum_ff;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               n_in = req_value_in;
               k_in = req_radix;
               if (trivial) begin
                  sum_in   = req_value_in;
                  state_in = ST_DONE;
               end else begin
                  sum_in   = '0;
                  state_in = ST_LAUNCH;
               end
            end
         end
         ST_LAUNCH: begin
            div_start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_done) begin
               sum_in   = sum_ff + div_rem;
               n_in     = div_quot;
               state_in = (div_quot == '0) ? ST_DONE : ST_LAUNCH;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      k_ff   <= k_in;
      sum_ff <= sum_in;
   end

   // handshake and response
   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = (state_ff == ST_DONE);
   assign rsp_digit_sum = sum_ff;

   // checks
   `RKDS_ASSERT_NXT(a_rsp_one_cycle, clock, reset, rsp_valid, !rsp_valid, "rsp held twice")
   `RKDS_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy, "busy not raised")
   `RKDS_ASSERT_IMP(a_done_in_wait, clock, reset, div_done, state_ff == ST_WAIT, "stray done")
   `RKDS_ASSERT_IMP(a_div_launch, clock, reset, div_start, state_ff == ST_LAUNCH, "stray launch")

endmodule : radix_k_digit_sum_top

`default_nettype wire

// File: tb/radix_k_digit_sum_top_tb.sv
// ----------------------------------------------------------------------------
// radix_k_digit_sum_top_tb
// self-checking bench for the base-k digit sum block
// ----------------------------------------------------------------------------
// the sender issues directed corner values and then three random phases with
// varying request gaps. every accepted request is turned into an expected
// digit sum by a behavioral model in the tracker class. every response strobe
// is compared with the oldest expected sum. a watchdog ends the run when no
// transaction moves for too long.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_k_digit_sum_top_tb;
   import rkds_pkg::*;

   localparam int VW          = VALUE_WIDTH_DEF;
   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_WAIT  = 40;

   typedef logic [VW-1:0] word_type;

   // expected digit sums, oldest first
   class digit_sum_tracker;
      word_type    expected_sums[$];
      int unsigned mismatches;

      function new();
         mismatches = 0;
      endfunction

      // digit sum of n in base k, with k of 0 or 1 or above n giving n
      static function word_type base_k_digit_sum(word_type n, word_type k);
         logic [63:0] rest;
         logic [63:0] total;
         if (k <= 1 || k > n)
            return n;
         rest  = n;
         total = 0;
         while (rest != 0) begin
            total = total + (rest % k);
            rest  = rest / k;
         end
         return total[VW-1:0];
      endfunction

      function void note_request(word_type n, word_type k);
         expected_sums.push_back(base_k_digit_sum(n, k));
      endfunction

      function void check_response(word_type actual);
         word_type want;
         if (expected_sums.size() == 0) begin
            $error("digit_sum: response %0d with no request outstanding", actual);
            mismatches++;
            return;
         end
         want = expected_sums.pop_front();
         if (actual !== want) begin
            $error("digit_sum mismatch: expected %0d, actual %0d", want, actual);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_sums.size();
      endfunction
   endclass

   logic     clock         = 1'b0;
   logic     reset         = 1'b1;
   logic     start         = 1'b0;
   word_type req_value_in  = '0;
   word_type req_radix     = '0;
   logic     busy;
   logic     rsp_valid;
   word_type rsp_digit_sum;

   digit_sum_tracker sums = new();
   int unsigned      idle_cycles = 0;

   radix_k_digit_sum_top #(.VALUE_WIDTH(VW)) uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value_in  (req_value_in),
      .req_radix     (req_radix),
      .rsp_valid     (rsp_valid),
      .rsp_digit_sum (rsp_digit_sum)
   );

   // clock, period 10
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // request and response monitor, sampled at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            sums.note_request(req_value_in, req_radix);
         if (rsp_valid)
            sums.check_response(rsp_digit_sum);
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // random gap before the next request
   task automatic sender_gap(input int unsigned pct);
      if ($urandom_range(99) < pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < pct);
      end
   endtask

   // present one request and hold it until the block takes it
   task automatic send_query(input word_type n, input word_type k, input int unsigned pct);
      sender_gap(pct);
      req_value_in <= n;
      req_radix    <= k;
      start        <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // hold off until every outstanding response has come back
   task automatic drain_responses();
      start <= 1'b0;
      // let the monitor record the request taken at the last edge
      @(posedge clock);
      while (sums.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // random queries with a mix of radix classes
   task automatic random_queries(input int count, input int unsigned pct);
      word_type n;
      word_type k;
      int       pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         n    = $urandom >> $urandom_range(VW - 1, 0);
         if (pick < 10) begin
            // binary, the slowest case
            k = 2;
         end else if (pick < 45) begin
            k = $urandom_range(16, 3);
         end else if (pick < 60) begin
            n = $urandom;
            k = $urandom_range(1000, 17);
         end else if (pick < 70) begin
            n = $urandom;
            k = $urandom >> $urandom_range(20, 0);
         end else if (pick < 80) begin
            // radix zero or one passes the value through
            n = $urandom;
            k = $urandom_range(1, 0);
         end else if (pick < 90) begin
            // radix just below, at or just above the value
            k = n + $urandom_range(2, 0) - 1;
         end else begin
            n = $urandom;
            k = $urandom;
         end
         send_query(n, k, pct);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corner values and special cases
      send_query('0, 1, 15);
      send_query('0, 2, 15);
      send_query('0, '0, 15);
      send_query('1, 2, 15);
      send_query(1, 2, 15);
      send_query(2, 2, 15);
      send_query(5, 5, 15);
      send_query(6, 5, 15);
      send_query(4, 5, 15);
      send_query('1, '1, 15);
      send_query({VW{1'b1}} - 1, '1, 15);
      send_query('1, 1, 15);
      send_query('1, '0, 15);
      send_query('1, 3, 15);
      send_query('1, 10, 15);
      send_query('1, 16, 15);
      send_query('1, 65536, 15);
      send_query({1'b1, {(VW - 1){1'b0}}}, 2, 15);
      send_query({1'b1, {(VW - 1){1'b0}}}, {1'b1, {(VW - 1){1'b0}}}, 15);
      send_query(32'h1234_5678, 10, 15);
      send_query(32'haaaa_aaaa, 32'h5555_5555, 15);

      // light sender gaps
      random_queries(190, 15);
      drain_responses();
      // heavy sender gaps
      random_queries(190, 66);
      drain_responses();
      // back-to-back requests
      random_queries(180, 0);

      start <= 1'b0;
      @(posedge clock);
      while (sums.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (sums.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule : radix_k_digit_sum_top_tb

`default_nettype wire
